/* rtl/clti_pkg.sv */
// shared types, codes and address map for the core-local timer interrupter
// no dependencies; imported by every module of the block
`default_nettype none

package clti_pkg;

   // hart slots: the count of harts, capped at the four bits of the present mask
   localparam int NUM_HARTS  = 4;
   localparam int HART_SLOTS = (NUM_HARTS < 4) ? NUM_HARTS : 4;
   localparam int HART_IDX_W = 2;

   // address map
   localparam logic [19:0] SOFT_BASE   = 20'h00000;
   localparam logic [19:0] CMP_BASE    = 20'h04000;
   localparam logic [19:0] TIME_BASE   = 20'h0bff8;
   localparam logic [19:0] TIME_END    = 20'h0c000;
   localparam logic [20:0] WINDOW_SIZE = 21'd786432;

   // action codes
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;

   // region codes
   localparam logic [1:0] RGN_SOFT = 2'd0;
   localparam logic [1:0] RGN_CMP  = 2'd1;
   localparam logic [1:0] RGN_TIME = 2'd2;
   localparam logic [1:0] RGN_NONE = 2'd3;

   // decoded access; part a is the whole access or the low word of a split,
   // part b the high word of a split eight-byte soft access
   typedef struct packed {
      logic                  tick;
      logic                  rd;
      logic                  wr;
      logic                  fault;
      logic                  split;
      logic [1:0]            rgn_a;
      logic                  hart_ok_a;
      logic [HART_IDX_W-1:0] hart_a;
      logic [2:0]            byte_a;
      logic [3:0]            len_a;
      logic                  cmp_b;
      logic                  hart_ok_b;
      logic [HART_IDX_W-1:0] hart_b;
      logic [2:0]            byte_b;
   } clti_access_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic        status;
      logic [3:0]  software_irq;
      logic [3:0]  timer_irq;
      logic [63:0] time_now;
   } clti_result_type;

endpackage

`default_nettype wire

/* rtl/clti_decode.sv */
// address and action decode for one beat
// depends on clti_pkg
`default_nettype none

module clti_decode
   import clti_pkg::*;
(
   input  wire logic [1:0]      action,
   input  wire logic [19:0]     offset,
   input  wire logic [3:0]      length,
   output clti_access_type      acc
);

   logic [19:0] rel_a;
   logic [19:0] id_a;
   logic [19:0] off_b;
   logic [19:0] rel_b;
   logic [19:0] id_b;
   logic [20:0] end_a;
   logic        len_bad;
   logic        is_soft;

   always_comb begin
      acc = '0;

      unique case (action)
         ACT_TICK:  acc.tick = 1'b1;
         ACT_READ:  acc.rd   = 1'b1;
         ACT_WRITE: acc.wr   = 1'b1;
         default:   acc.tick = 1'b0;
      endcase

      is_soft = offset < CMP_BASE;
      len_bad = length > 4'd8;
      end_a   = {1'b0, offset} + {17'd0, length};

      if (is_soft) begin
         acc.rgn_a = RGN_SOFT;
         rel_a     = offset - SOFT_BASE;
         id_a      = rel_a >> 2;
      end else if (offset < TIME_BASE) begin
         acc.rgn_a = RGN_CMP;
         rel_a     = offset - CMP_BASE;
         id_a      = rel_a >> 3;
      end else if (offset < TIME_END) begin
         acc.rgn_a = RGN_TIME;
         rel_a     = '0;
         id_a      = '0;
      end else begin
         acc.rgn_a = RGN_NONE;
         rel_a     = '0;
         id_a      = '0;
      end

      acc.hart_ok_a = id_a < 20'(HART_SLOTS);
      acc.hart_a    = id_a[HART_IDX_W-1:0];
      acc.byte_a    = offset[2:0];
      acc.split     = is_soft && (length == 4'd8);
      acc.len_a     = acc.split ? 4'd4 : length;

      // second word of a split, may land on the first compare
      off_b     = offset + 20'd4;
      acc.cmp_b = off_b >= CMP_BASE;
      if (acc.cmp_b) begin
         rel_b = off_b - CMP_BASE;
         id_b  = rel_b >> 3;
      end else begin
         rel_b = off_b - SOFT_BASE;
         id_b  = rel_b >> 2;
      end
      acc.hart_ok_b = id_b < 20'(HART_SLOTS);
      acc.hart_b    = id_b[HART_IDX_W-1:0];
      acc.byte_b    = off_b[2:0];

      acc.fault = (acc.rd || acc.wr) &&
                  (len_bad || (acc.rgn_a == RGN_NONE && end_a > WINDOW_SIZE));
   end

endmodule

`default_nettype wire

/* rtl/clti_state.sv */
// time counter, compares and soft bits, with the byte-lane access logic
// depends on clti_pkg; driven by the decoded access from clti_decode
`default_nettype none

module clti_state
   import clti_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire clti_access_type acc,
   input  wire logic [63:0]     write_data,
   input  wire logic [31:0]     tick_count,
   input  wire logic [3:0]      present,
   output clti_result_type      res
);

   logic [63:0] time_ff;
   logic [63:0] time_in;
   logic [63:0] cmp_ff [HART_SLOTS];
   logic [63:0] cmp_in [HART_SLOTS];
   logic [HART_SLOTS-1:0] soft_ff;
   logic [HART_SLOTS-1:0] soft_in;

   logic [HART_SLOTS-1:0] hit_a;
   logic [HART_SLOTS-1:0] hit_b;
   logic [63:0] word_a;
   logic [63:0] word_b;
   logic        soft_a;
   logic        soft_b;
   logic [63:0] rd_a;
   logic [63:0] rd_b;
   logic [63:0] wd_b;
   logic        wr_ok;

   // byte i of the beat maps to register byte (addr + i) mod 8
   function automatic logic [63:0] get_bytes(input logic [63:0] word, input logic [2:0] a,
                                             input logic [3:0] len);
      logic [63:0] r;
      logic [2:0]  pos;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         pos = a + 3'(i);
         if (4'(i) < len) r[8*i +: 8] = word[{pos, 3'b000} +: 8];
      end
      return r;
   endfunction

   function automatic logic [63:0] put_bytes(input logic [63:0] word, input logic [2:0] a,
                                             input logic [3:0] len, input logic [63:0] data);
      logic [63:0] w;
      logic [2:0]  pos;
      w = word;
      for (int i = 0; i < 8; i++) begin
         pos = a + 3'(i);
         if (4'(i) < len) w[{pos, 3'b000} +: 8] = data[8*i +: 8];
      end
      return w;
   endfunction

   // soft word holds only bit 0, so only lanes landing on byte 0 matter
   function automatic logic [63:0] get_soft(input logic v, input logic [1:0] a,
                                            input logic [3:0] len);
      logic [63:0] r;
      logic [1:0]  pos;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         pos = a + 2'(i);
         if (4'(i) < len && pos == 2'd0) r[8*i] = v;
      end
      return r;
   endfunction

   function automatic logic put_soft(input logic [1:0] a, input logic [3:0] len,
                                     input logic [63:0] data);
      logic       b;
      logic [1:0] pos;
      b = 1'b0;
      for (int i = 0; i < 8; i++) begin
         pos = a + 2'(i);
         if (4'(i) < len && pos == 2'd0) b = data[8*i];
      end
      return b;
   endfunction

   always_comb begin
      word_a = '0;
      word_b = '0;
      soft_a = 1'b0;
      soft_b = 1'b0;
      for (int h = 0; h < HART_SLOTS; h++) begin
         hit_a[h] = acc.hart_ok_a && (acc.hart_a == HART_IDX_W'(h)) && present[h];
         hit_b[h] = acc.hart_ok_b && (acc.hart_b == HART_IDX_W'(h)) && present[h];
         word_a   = word_a | (hit_a[h] ? cmp_ff[h] : 64'd0);
         word_b   = word_b | (hit_b[h] ? cmp_ff[h] : 64'd0);
         soft_a   = soft_a | (hit_a[h] & soft_ff[h]);
         soft_b   = soft_b | (hit_b[h] & soft_ff[h]);
      end
   end

   // read path
   always_comb begin
      case (acc.rgn_a)
         RGN_SOFT: rd_a = get_soft(soft_a, acc.byte_a[1:0], acc.len_a);
         RGN_CMP:  rd_a = get_bytes(word_a, acc.byte_a, acc.len_a);
         RGN_TIME: rd_a = get_bytes(time_ff, acc.byte_a, acc.len_a);
         default:  rd_a = '0;
      endcase
      rd_b = acc.cmp_b ? get_bytes(word_b, acc.byte_b, 4'd4)
                       : get_soft(soft_b, acc.byte_b[1:0], 4'd4);
   end

   // write path and tick
   always_comb begin
      wr_ok = acc.wr && !acc.fault;
      wd_b  = {32'd0, write_data[63:32]};

      for (int h = 0; h < HART_SLOTS; h++) begin
         if (wr_ok && acc.split && !acc.cmp_b && hit_b[h] && acc.byte_b[1:0] == 2'd0) begin
            soft_in[h] = put_soft(acc.byte_b[1:0], 4'd4, wd_b);
         end else if (wr_ok && acc.rgn_a == RGN_SOFT && hit_a[h] &&
                      acc.byte_a[1:0] == 2'd0) begin
            soft_in[h] = put_soft(acc.byte_a[1:0], acc.len_a, write_data);
         end else begin
            soft_in[h] = soft_ff[h];
         end

         if (wr_ok && acc.split && acc.cmp_b && hit_b[h]) begin
            cmp_in[h] = put_bytes(cmp_ff[h], acc.byte_b, 4'd4, wd_b);
         end else if (wr_ok && acc.rgn_a == RGN_CMP && hit_a[h]) begin
            cmp_in[h] = put_bytes(cmp_ff[h], acc.byte_a, acc.len_a, write_data);
         end else begin
            cmp_in[h] = cmp_ff[h];
         end
      end

      if (acc.tick) begin
         time_in = time_ff + {32'd0, tick_count};
      end else if (wr_ok && acc.rgn_a == RGN_TIME) begin
         time_in = put_bytes(time_ff, acc.byte_a, acc.len_a, write_data);
      end else begin
         time_in = time_ff;
      end
   end

   // result from the post-beat state
   always_comb begin
      res.software_irq = '0;
      res.timer_irq    = '0;
      for (int h = 0; h < HART_SLOTS; h++) begin
         res.software_irq[h] = present[h] & soft_in[h];
         res.timer_irq[h]    = present[h] & (time_in >= cmp_in[h]);
      end
      res.read_data = (acc.rd && !acc.fault) ?
                      (acc.split ? {rd_b[31:0], rd_a[31:0]} : rd_a) : 64'd0;
      res.status    = acc.fault;
      res.time_now  = time_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
         soft_ff <= '0;
         for (int h = 0; h < HART_SLOTS; h++) cmp_ff[h] <= '0;
      end else if (advance) begin
         time_ff <= time_in;
         soft_ff <= soft_in;
         for (int h = 0; h < HART_SLOTS; h++) cmp_ff[h] <= cmp_in[h];
      end
   end

endmodule

`default_nettype wire

/* rtl/core_local_timer_interrupter_core.sv */
// core-local timer interrupter: time counter, per-hart compares and soft bits
// a beat passes through the request register, then the response register; one beat per cycle while rsp_stall is low
// throughput is set by the single pass from the request register to the response register
// synchronous active-high reset clears time, compares, soft bits and both valids;
// the hart present mask resets to all ones. depends on clti_pkg, clti_decode, clti_state
`default_nettype none

module core_local_timer_interrupter_core
   import clti_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [19:0] req_offset,
   input  wire logic [3:0]  req_length,
   input  wire logic [63:0] req_write_data,
   input  wire logic [31:0] req_tick_count,

   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_read_data,
   output logic             rsp_status,
   output logic [3:0]       rsp_software_irq,
   output logic [3:0]       rsp_timer_irq,
   output logic [63:0]      rsp_time_now,

   // hart present mask write port
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_harts_present
);

   // request register
   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic [1:0]  action_ff;
   logic [19:0] offset_ff;
   logic [3:0]  length_ff;
   logic [63:0] wdata_ff;
   logic [31:0] ticks_ff;

   // response register
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   clti_result_type rsp_ff;

   logic [3:0]      present_ff;
   logic            out_free;
   logic            advance;
   logic            req_take;
   clti_access_type acc;
   clti_result_type res;

   // the response slot is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // the request beat moves into the response register and commits its state change
   assign advance   = s1_valid_ff && out_free;
   // a new beat is taken whenever the request register empties or is empty
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         action_ff <= req_action;
         offset_ff <= req_offset;
         length_ff <= req_length;
         wdata_ff  <= req_write_data;
         ticks_ff  <= req_tick_count;
      end
      if (advance) begin
         rsp_ff <= res;
      end
   end

   // present mask, to be written by the user only while the block is idle; the block does not enforce it
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 4'hf;
      end else if (csr_valid && csr_ready) begin
         present_ff <= csr_harts_present;
      end
   end

   clti_decode u_decode (
      .action (action_ff),
      .offset (offset_ff),
      .length (length_ff),
      .acc    (acc)
   );

   clti_state u_state (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .acc        (acc),
      .write_data (wdata_ff),
      .tick_count (ticks_ff),
      .present    (present_ff),
      .res        (res)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_ff.read_data;
   assign rsp_status       = rsp_ff.status;
   assign rsp_software_irq = rsp_ff.software_irq;
   assign rsp_timer_irq    = rsp_ff.timer_irq;
   assign rsp_time_now     = rsp_ff.time_now;

`ifndef ASSERT_OFF
   // a held request beat is never dropped
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff)
      else $error("request beat lost while held");

   // a committed beat shows up on the response side next cycle
   a_rsp_after_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("committed beat missing from response register");

   // a faulted access never returns data
   a_fault_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status) |-> (rsp_ff.read_data == 64'd0))
      else $error("read data on a faulted beat");

   // interrupt bits only for harts present
   a_irq_present: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (((rsp_ff.timer_irq | rsp_ff.software_irq) & ~present_ff) == 4'd0))
      else $error("interrupt pending on an absent hart");
`endif

endmodule

`default_nettype wire

/* dv/clint_result_checker.sv */
`timescale 1ns / 100ps
// clint_result_checker: mirrors the time counter, compares and soft bits of the block
// and checks every response beat against the mirrored result; depends on clti_pkg

module clint_result_checker
   import clti_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [19:0] req_offset,
   input  wire logic [3:0]  req_length,
   input  wire logic [63:0] req_write_data,
   input  wire logic [31:0] req_tick_count,

   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [63:0] rsp_read_data,
   input  wire logic        rsp_status,
   input  wire logic [3:0]  rsp_software_irq,
   input  wire logic [3:0]  rsp_timer_irq,
   input  wire logic [63:0] rsp_time_now,

   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [3:0]  csr_harts_present,

   output int               mismatch_count,
   output int               awaited_count
);

   logic [63:0]          mtime;
   logic [63:0]          mtimecmp [NUM_HARTS];
   logic [NUM_HARTS-1:0] msip;
   logic [3:0]           present;
   clti_result_type      awaited_results [$];
   int                   errs = 0;

   function automatic bit hart_here(longint unsigned id);
      if (id >= 4 || id >= NUM_HARTS) return 1'b0;
      return present[id];
   endfunction

   // byte lanes wrap inside the register
   function automatic logic [63:0] pick_bytes(logic [63:0] word, int unsigned size,
                                              longint unsigned addr, int unsigned len);
      logic [63:0] r;
      int unsigned i, sh;
      r = '0;
      for (i = 0; i < len && i < 8; i++) begin
         sh = 8 * ((addr + i) % size);
         r |= ((word >> sh) & 64'hff) << (8 * i);
      end
      return r;
   endfunction

   function automatic logic [63:0] place_bytes(logic [63:0] word, int unsigned size,
                                               longint unsigned addr, int unsigned len,
                                               logic [63:0] data);
      int unsigned i, sh;
      for (i = 0; i < len && i < 8; i++) begin
         sh = 8 * ((addr + i) % size);
         word = (word & ~(64'hff << sh)) | (((data >> (8 * i)) & 64'hff) << sh);
      end
      return word;
   endfunction

   function automatic bit single_access(bit wr, longint unsigned addr, int unsigned len,
                                        logic [63:0] data, output logic [63:0] rd);
      longint unsigned id;
      logic [63:0]     word;
      rd = '0;
      if (addr < CMP_BASE) begin
         id = addr / 4;
         if (wr) begin
            word = place_bytes(64'd0, 4, addr, len, data);
            if (addr % 4 == 0 && hart_here(id)) msip[id] = word[0];
         end else begin
            word = (hart_here(id) && msip[id]) ? 64'd1 : 64'd0;
            rd = pick_bytes(word, 4, addr, len);
         end
      end else if (addr < TIME_BASE) begin
         id = (addr - CMP_BASE) / 8;
         if (wr) begin
            if (hart_here(id)) mtimecmp[id] = place_bytes(mtimecmp[id], 8, addr, len, data);
         end else begin
            word = hart_here(id) ? mtimecmp[id] : 64'd0;
            rd = pick_bytes(word, 8, addr, len);
         end
      end else if (addr < TIME_END) begin
         if (wr) mtime = place_bytes(mtime, 8, addr, len, data);
         else rd = pick_bytes(mtime, 8, addr, len);
      end else if (addr + len > WINDOW_SIZE) begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // eight-byte soft accesses go as two words
   function automatic bit bus_access(bit wr, longint unsigned addr, int unsigned len,
                                     logic [63:0] data, output logic [63:0] rd);
      logic [63:0] lo, hi;
      bit          ok;
      rd = '0;
      if (len > 8) return 1'b0;
      if (addr < CMP_BASE && len == 8) begin
         ok = single_access(wr, addr, 4, {32'd0, data[31:0]}, lo);
         if (ok) ok = single_access(wr, addr + 4, 4, {32'd0, data[63:32]}, hi);
         if (!ok) return 1'b0;
         rd = {hi[31:0], lo[31:0]};
         return 1'b1;
      end
      ok = single_access(wr, addr, len, data, rd);
      if (!ok) rd = '0;
      return ok;
   endfunction

   function automatic clti_result_type next_result(logic [1:0] act, logic [19:0] off,
                                                   logic [3:0] len, logic [63:0] wdata,
                                                   logic [31:0] ticks);
      clti_result_type r;
      logic [63:0]     rd;
      bit              ok;
      int              h;
      rd = '0;
      ok = 1'b1;
      case (act)
         ACT_TICK:  mtime = mtime + {32'd0, ticks};
         ACT_READ:  ok = bus_access(1'b0, off, len, 64'd0, rd);
         ACT_WRITE: ok = bus_access(1'b1, off, len, wdata, rd);
         default:   ;
      endcase
      if (act != ACT_READ) rd = '0;
      r.read_data    = rd;
      r.status       = !ok;
      r.software_irq = '0;
      r.timer_irq    = '0;
      for (h = 0; h < NUM_HARTS; h++) begin
         if (hart_here(h)) begin
            r.software_irq[h] = msip[h];
            r.timer_irq[h]    = (mtime >= mtimecmp[h]);
         end
      end
      r.time_now = mtime;
      return r;
   endfunction

   function automatic void field_check(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         errs++;
         if (errs <= 100)
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
         else if (errs == 101)
            $display("%0t: further mismatches not shown", $time);
      end
   endfunction

   always @(posedge clock) begin : watch
      clti_result_type want;
      if (reset) begin
         mtime = '0;
         foreach (mtimecmp[i]) mtimecmp[i] = '0;
         msip    = '0;
         present = 4'hf;
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               errs++;
               $display("%0t: response beat with nothing awaited, expected none, got time %h",
                        $time, rsp_time_now);
            end else begin
               want = awaited_results.pop_front();
               field_check("read_data", want.read_data, rsp_read_data);
               field_check("status", want.status, rsp_status);
               field_check("software_irq", want.software_irq, rsp_software_irq);
               field_check("timer_irq", want.timer_irq, rsp_timer_irq);
               field_check("time_now", want.time_now, rsp_time_now);
            end
         end
         if (csr_valid && csr_ready) present = csr_harts_present;
         if (req_valid && !req_stall)
            awaited_results.push_back(next_result(req_action, req_offset, req_length,
                                                  req_write_data, req_tick_count));
      end
      mismatch_count <= errs;
      awaited_count  <= awaited_results.size();
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: clock, reset and stimulus for core_local_timer_interrupter_core, with the verdict
// depends on clti_pkg, the block itself and clint_result_checker

module tb_top;
   import clti_pkg::*;

   // the fourth action code has no name in the package; the block must treat it as a no-op
   localparam logic [1:0] ACT_SPARE = 2'd3;

   logic        clock;
   logic        reset;

   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [19:0] req_offset;
   logic [3:0]  req_length;
   logic [63:0] req_write_data;
   logic [31:0] req_tick_count;

   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_read_data;
   logic        rsp_status;
   logic [3:0]  rsp_software_irq;
   logic [3:0]  rsp_timer_irq;
   logic [63:0] rsp_time_now;

   logic        csr_valid;
   logic        csr_ready;
   logic [3:0]  csr_harts_present;

   int          mismatches;
   int          awaited_count;

   // stimulus bookkeeping
   int          burst_left;
   bit          steady;        // sender offers back to back, no gaps
   logic        hold_off_go;   // asks the receiver for one long hold-off
   int          tick_beats, read_beats, write_beats, spare_beats, mask_writes;

   core_local_timer_interrupter_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_offset        (req_offset),
      .req_length        (req_length),
      .req_write_data    (req_write_data),
      .req_tick_count    (req_tick_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_data     (rsp_read_data),
      .rsp_status        (rsp_status),
      .rsp_software_irq  (rsp_software_irq),
      .rsp_timer_irq     (rsp_timer_irq),
      .rsp_time_now      (rsp_time_now),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_harts_present (csr_harts_present)
   );

   // the checker sits beside the block and only watches its ports
   clint_result_checker result_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_offset        (req_offset),
      .req_length        (req_length),
      .req_write_data    (req_write_data),
      .req_tick_count    (req_tick_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_data     (rsp_read_data),
      .rsp_status        (rsp_status),
      .rsp_software_irq  (rsp_software_irq),
      .rsp_timer_irq     (rsp_timer_irq),
      .rsp_time_now      (rsp_time_now),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_harts_present (csr_harts_present),
      .mismatch_count    (mismatches),
      .awaited_count     (awaited_count)
   );

   // 20 ns period
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // offers one request beat and returns at the edge that takes it;
   // between bursts the sender idles for a random number of cycles
   task automatic send_beat(logic [1:0] act, logic [19:0] off, logic [3:0] len,
                            logic [63:0] wd, logic [31:0] tc);
      int unsigned gap;
      if (burst_left == 0 && !steady) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      if (burst_left > 0) burst_left--;
      req_valid      <= 1'b1;
      req_action     <= act;
      req_offset     <= off;
      req_length     <= len;
      req_write_data <= wd;
      req_tick_count <= tc;
      // payload holds still while stalled
      do @(posedge clock); while (req_stall);
      case (act)
         ACT_TICK:  tick_beats++;
         ACT_READ:  read_beats++;
         ACT_WRITE: write_beats++;
         default:   spare_beats++;
      endcase
   endtask

   // sender stops and waits until every awaited response has come back,
   // plus a settling wait for the request and response registers to empty
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      burst_left = 0;
   endtask

   // hart mask is only rewritten with the block idle
   task automatic set_hart_mask(logic [3:0] mask);
      wait_for_quiet();
      csr_valid         <= 1'b1;
      csr_harts_present <= mask;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mask_writes++;
   endtask

   // random beat, weighted towards the live parts of the address map
   task automatic random_beat();
      logic [1:0]  act;
      logic [19:0] off;
      logic [3:0]  len;
      logic [63:0] wd;
      logic [31:0] tc;
      int unsigned pick;

      pick = $urandom_range(0, 19);
      if (pick < 5) act = ACT_TICK;
      else if (pick < 12) act = ACT_READ;
      else if (pick < 19) act = ACT_WRITE;
      else act = ACT_SPARE;

      case ($urandom_range(0, 9))
         0, 1: off = 20'($urandom_range(0, 'h1f));                  // soft words, present and not
         2:    off = 20'($urandom_range(0, 'h3fff));                // whole soft region
         3, 4: off = CMP_BASE + 20'($urandom_range(0, 'h27));       // compares of all slots
         5:    off = CMP_BASE + 20'($urandom_range(0, 'h7ff7));     // far compare region
         6:    off = TIME_BASE + 20'($urandom_range(0, 7));         // time register lanes
         7:    off = 20'($urandom_range('hc000, 'hfffff));          // reserved or outside
         8:    off = 20'(WINDOW_SIZE - 21'($urandom_range(0, 12))); // window edge
         default: off = 20'($urandom_range(0, 'hfffff));
      endcase
      // keep soft accesses mostly word aligned so the bits actually move
      if (off < CMP_BASE && $urandom_range(0, 3) != 0) off[1:0] = 2'b00;

      if ($urandom_range(0, 6) == 0) len = 4'($urandom_range(9, 15));
      else begin
         case ($urandom_range(0, 3))
            0:       len = 4'd4;
            1:       len = 4'd8;
            default: len = 4'($urandom_range(0, 8));
         endcase
      end

      // small data lets time and compares meet so the timer bits toggle
      if ($urandom_range(0, 4) < 2) wd = 64'($urandom_range(0, 3000));
      else wd = {$urandom, $urandom};

      case ($urandom_range(0, 9))
         0, 1:    tc = $urandom;
         2:       tc = 32'hffff_ffff;
         default: tc = 32'($urandom_range(0, 300));
      endcase

      send_beat(act, off, len, wd, tc);
   endtask

   // receiver: stall pattern of its own in stretches of random length,
   // plus one long hold-off on request so the block fills and stalls its input
   initial begin : receiver
      int unsigned mode, stretch, beat_phase;
      bit          held;
      rsp_stall  <= 1'b0;
      held       = 1'b0;
      beat_phase = 0;
      forever begin
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(20, 150);
         repeat (stretch) begin
            @(posedge clock);
            if (hold_off_go && !held) begin
               rsp_stall <= 1'b1;
               held = 1'b1;
               repeat (64) @(posedge clock);
            end
            if (!hold_off_go) held = 1'b0;
            beat_phase++;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 9) < 7);
               default: rsp_stall <= ((beat_phase % 5) < 2);
            endcase
         end
      end
   end

   // guard against a hung handshake; several times the slowest legal run
   initial begin : watchdog
      #8_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      int unsigned p, idx;
      logic [3:0]  mask;

      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_action        <= ACT_TICK;
      req_offset        <= '0;
      req_length        <= '0;
      req_write_data    <= '0;
      req_tick_count    <= '0;
      csr_valid         <= 1'b0;
      csr_harts_present <= 4'hf;
      hold_off_go       <= 1'b0;
      burst_left  = 0;
      steady      = 1'b0;
      tick_beats  = 0;
      read_beats  = 0;
      write_beats = 0;
      spare_beats = 0;
      mask_writes = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed beats with all harts present (reset mask)
      send_beat(ACT_READ,  TIME_BASE, 4'd8, 64'd0, 32'd0);                    // time after reset
      send_beat(ACT_TICK,  20'd0, 4'd0, 64'd0, 32'hffff_ffff);                 // largest tick
      send_beat(ACT_WRITE, TIME_BASE, 4'd8, 64'hffff_ffff_ffff_fff0, 32'd0);   // time near top
      send_beat(ACT_TICK,  20'd0, 4'd0, 64'd0, 32'h20);                        // time wraps
      send_beat(ACT_WRITE, CMP_BASE, 4'd8, 64'h100, 32'd0);                    // hart 0 compare
      send_beat(ACT_WRITE, CMP_BASE + 20'h18, 4'd8, '1, 32'd0);                // hart 3 compare max
      send_beat(ACT_READ,  CMP_BASE + 20'h18, 4'd8, 64'd0, 32'd0);
      send_beat(ACT_READ,  CMP_BASE + 20'h6, 4'd4, 64'd0, 32'd0);              // lanes wrap in reg
      send_beat(ACT_WRITE, SOFT_BASE, 4'd4, 64'd1, 32'd0);                     // hart 0 soft set
      send_beat(ACT_WRITE, SOFT_BASE + 20'h4, 4'd8, 64'h1_0000_0001, 32'd0);   // split, harts 1 and 2
      send_beat(ACT_READ,  SOFT_BASE, 4'd8, 64'd0, 32'd0);                     // split read
      send_beat(ACT_WRITE, SOFT_BASE + 20'h2, 4'd4, 64'd0, 32'd0);             // unaligned, ignored
      send_beat(ACT_WRITE, SOFT_BASE + 20'h4, 4'd0, 64'd1, 32'd0);             // zero length clears
      send_beat(ACT_WRITE, 20'h03ffc, 4'd8, 64'h0000_0200_0000_0000, 32'd0);   // split into compare
      send_beat(ACT_READ,  20'h03ffc, 4'd8, 64'd0, 32'd0);
      send_beat(ACT_READ,  SOFT_BASE, 4'd9, 64'd0, 32'd0);                     // too long, fault
      send_beat(ACT_WRITE, CMP_BASE, 4'd15, '1, 32'd0);                        // longest, fault
      send_beat(ACT_READ,  TIME_END, 4'd4, 64'd0, 32'd0);                      // reserved, zero
      send_beat(ACT_READ,  20'(WINDOW_SIZE - 21'd4), 4'd4, 64'd0, 32'd0);      // last word in window
      send_beat(ACT_READ,  20'(WINDOW_SIZE - 21'd2), 4'd4, 64'd0, 32'd0);      // crosses window end
      send_beat(ACT_WRITE, 20'hfffff, 4'd1, '1, 32'd0);                        // top offset, fault
      send_beat(ACT_SPARE, 20'hfffff, 4'd15, '1, 32'hffff_ffff);               // unused code
      send_beat(ACT_WRITE, TIME_BASE + 20'h4, 4'd4, 64'd0, 32'd0);             // upper time half
      send_beat(ACT_READ,  CMP_BASE + 20'h20, 4'd8, 64'd0, 32'd0);             // slot past harts
      send_beat(ACT_TICK,  20'd0, 4'd0, 64'd0, 32'd0);                         // zero tick

      // random phases, each under its own hart mask, empty and full among them
      for (p = 0; p < 6; p++) begin
         case (p)
            0:       mask = 4'h0;
            1:       mask = 4'hf;
            2:       mask = 4'h5;
            3:       mask = 4'ha;
            4:       mask = 4'($urandom_range(0, 15));
            default: mask = 4'hf;
         endcase
         set_hart_mask(mask);
         steady = (p == 2);   // one phase with no sender gaps at all
         for (idx = 0; idx < 210; idx++) begin
            if (p == 1 && idx == 100) begin
               // back-to-back beats into a receiver that holds off for a long stretch
               hold_off_go <= 1'b1;
               steady = 1'b1;
               repeat (30) random_beat();
               hold_off_go <= 1'b0;
               steady = 1'b0;
            end
            if (p == 3 && idx == 120) wait_for_quiet();   // sender pauses until drained
            random_beat();
         end
      end

      wait_for_quiet();
      repeat (6) @(posedge clock);

      $display("covered %0d request beats: %0d ticks, %0d reads, %0d writes, %0d unused-code",
               tick_beats + read_beats + write_beats + spare_beats,
               tick_beats, read_beats, write_beats, spare_beats);
      $display("under %0d hart mask settings with a long response hold-off, %0d mismatches",
               mask_writes + 1, mismatches);
      if (mismatches == 0 && awaited_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
